FILE: src/gprd_pkg.sv
// Shared types, codes and constants of the gamepad report deframer.
package gprd_pkg;

  // Number of payload bytes captured from each frame.
  localparam int CaptureLen = 12;
  localparam int CaptureIdxW = $clog2(CaptureLen);

  // Configuration port widths.
  localparam int CfgIndexW = 3;
  localparam int CfgDataW = 12;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] REG_START_MARKER = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_END_MARKER = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_NEUTRAL_LX = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_NEUTRAL_LY = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_NEUTRAL_RX = 3'd4;
  localparam logic [CfgIndexW-1:0] REG_NEUTRAL_RY = 3'd5;

  // Result status codes.
  localparam logic [1:0] STATUS_GOOD = 2'd0;
  localparam logic [1:0] STATUS_BAD_END = 2'd1;
  localparam logic [1:0] STATUS_SHORT = 2'd2;

  // Stick re-centering value.
  localparam logic [12:0] StickCentre = 13'd2048;

  // Low nibble mask used to unpack the sticks.
  localparam logic [7:0] NibbleMask = 8'h0F;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic [7:0]  start_marker;
    logic [7:0]  end_marker;
    logic [11:0] neutral_left_x;
    logic [11:0] neutral_left_y;
    logic [11:0] neutral_right_x;
    logic [11:0] neutral_right_y;
  } cfg_regs_t;

  // End-of-frame event from the parser to the result stage.
  typedef struct packed {
    logic                               fire;
    logic [1:0]                         status;
    logic [CaptureLen-1:0][7:0]         payload;
  } frame_evt_t;

endpackage

FILE: src/gprd_byte_if.sv
// Valid/ready channel that carries one received byte per item.
interface gprd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: src/gprd_report_if.sv
// Valid/ready channel that carries one decoded report per item.
interface gprd_report_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [7:0]         report_ident;
  logic [7:0]         timer_value;
  logic [7:0]         info_byte;
  logic [7:0]         buttons_low;
  logic [7:0]         buttons_mid;
  logic [7:0]         buttons_high;
  logic signed [12:0] left_x;
  logic signed [12:0] left_y;
  logic signed [12:0] right_x;
  logic signed [12:0] right_y;

  modport source (
    output valid, output status, output report_ident, output timer_value,
    output info_byte, output buttons_low, output buttons_mid, output buttons_high,
    output left_x, output left_y, output right_x, output right_y,
    input ready
  );
  modport sink (
    input valid, input status, input report_ident, input timer_value,
    input info_byte, input buttons_low, input buttons_mid, input buttons_high,
    input left_x, input left_y, input right_x, input right_y,
    output ready
  );
endinterface

FILE: src/gprd_cfg_if.sv
// Configuration write channel: register index and write data.
interface gprd_cfg_if
  import gprd_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CfgIndexW-1:0] index;
  logic [CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/gprd_cfg.sv
// Configuration register file of the deframer.
module gprd_cfg
  import gprd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  gprd_cfg_if.sink    cfg,
  output cfg_regs_t   regs
);

  // Writes are always taken; unknown indexes are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_START_MARKER: regs.start_marker <= cfg.data[7:0];
        REG_END_MARKER:   regs.end_marker <= cfg.data[7:0];
        REG_NEUTRAL_LX:   regs.neutral_left_x <= cfg.data;
        REG_NEUTRAL_LY:   regs.neutral_left_y <= cfg.data;
        REG_NEUTRAL_RX:   regs.neutral_right_x <= cfg.data;
        REG_NEUTRAL_RY:   regs.neutral_right_y <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

FILE: src/gprd_parser.sv
// Input byte register and frame parser with the payload capture store.
module gprd_parser
  import gprd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  gprd_byte_if.sink   rx,
  input  cfg_regs_t   regs,
  input  logic        res_free,
  output frame_evt_t  evt
);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_END = 2'd3;

  logic                       stage_valid;
  logic [7:0]                 stage_byte;
  logic [1:0]                 phase;
  logic [7:0]                 frame_length;
  logic [7:0]                 payload_count;
  logic [7:0]                 count_inc;
  logic [CaptureLen-1:0][7:0] payload_store;
  logic                       is_end;
  logic                       advance;

  // The held byte moves on unless it closes a frame and the result slot is full.
  assign is_end = (phase == PH_END);
  assign advance = stage_valid && (!is_end || res_free);
  assign rx.ready = !stage_valid || advance;
  assign count_inc = payload_count + 8'd1;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (rx.ready) begin
      stage_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      stage_byte <= rx.rx_byte;
    end
  end

  // Parse state machine.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      frame_length <= '0;
      payload_count <= '0;
    end else if (advance) begin
      unique case (phase)
        PH_HUNT: begin
          if (stage_byte == regs.start_marker) begin
            phase <= PH_LEN;
          end
        end
        PH_LEN: begin
          frame_length <= stage_byte;
          payload_count <= '0;
          phase <= (stage_byte == 8'd0) ? PH_END : PH_DATA;
        end
        PH_DATA: begin
          payload_count <= count_inc;
          if (count_inc == frame_length) begin
            phase <= PH_END;
          end
        end
        PH_END: begin
          phase <= PH_HUNT;
        end
        default: phase <= PH_HUNT;
      endcase
    end
  end

  // Capture the first payload bytes; later ones are only counted.
  always_ff @(posedge clk) begin
    if (advance && phase == PH_DATA && payload_count < 8'(CaptureLen)) begin
      payload_store[payload_count[CaptureIdxW-1:0]] <= stage_byte;
    end
  end

  // End-of-frame event; the end marker check takes priority over length.
  always_comb begin
    evt.fire = advance && is_end;
    evt.payload = payload_store;
    if (stage_byte != regs.end_marker) begin
      evt.status = STATUS_BAD_END;
    end else if (frame_length < 8'(CaptureLen)) begin
      evt.status = STATUS_SHORT;
    end else begin
      evt.status = STATUS_GOOD;
    end
  end

endmodule

FILE: src/gprd_result.sv
// Report decoding, stick re-centering and the result register.
module gprd_result
  import gprd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  frame_evt_t    evt,
  input  cfg_regs_t     regs,
  output logic          res_free,
  gprd_report_if.source report
);

  logic [11:0] raw_lx;
  logic [11:0] raw_ly;
  logic [11:0] raw_rx;
  logic [11:0] raw_ry;
  logic        good;

  function automatic logic [12:0] stick(input logic [11:0] raw, input logic [11:0] neutral);
    stick = {1'b0, raw} - StickCentre - {neutral[11], neutral};
  endfunction

  // Unpack the four 12-bit stick values.
  assign raw_lx = {evt.payload[7][3:0], evt.payload[6]};
  assign raw_ly = {evt.payload[8], evt.payload[7][7:4]};
  assign raw_rx = {evt.payload[10][3:0], evt.payload[9]};
  assign raw_ry = {evt.payload[11], 4'((evt.payload[10] & ~NibbleMask) >> 4)};
  assign good = (evt.status == STATUS_GOOD);

  // The slot frees when empty or when the receiver takes the held item.
  assign res_free = !report.valid || report.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      report.valid <= 1'b0;
    end else if (evt.fire) begin
      report.valid <= 1'b1;
    end else if (report.ready) begin
      report.valid <= 1'b0;
    end
  end

  // Result payload; all fields but the status read zero for a failed frame.
  always_ff @(posedge clk) begin
    if (evt.fire) begin
      report.status <= evt.status;
      report.report_ident <= good ? evt.payload[0] : '0;
      report.timer_value <= good ? evt.payload[1] : '0;
      report.info_byte <= good ? evt.payload[2] : '0;
      report.buttons_low <= good ? evt.payload[3] : '0;
      report.buttons_mid <= good ? evt.payload[4] : '0;
      report.buttons_high <= good ? evt.payload[5] : '0;
      report.left_x <= good ? stick(raw_lx, regs.neutral_left_x) : '0;
      report.left_y <= good ? stick(raw_ly, regs.neutral_left_y) : '0;
      report.right_x <= good ? stick(raw_rx, regs.neutral_right_x) : '0;
      report.right_y <= good ? stick(raw_ry, regs.neutral_right_y) : '0;
    end
  end

endmodule

FILE: src/gamepad_report_deframer_core.sv
// Top level of the gamepad report deframer.
//
// The rx channel takes one serial byte per item. The parser hunts for the
// start marker, reads a length byte, that many payload bytes and one end
// byte. Every end byte produces exactly one item on the report channel:
// a good frame gives the header bytes, the raw button bytes and four
// re-centered stick values; a wrong end marker or a length below twelve
// gives only a status code, with every other field zero.
// The cfg channel writes the markers and the neutral offsets; it is always
// ready and is meant to be used while no frame is in flight.
// Throughput is one byte per cycle while the rx channel is not stalled. Each
// byte passes through the input register; an accepted end byte then loads
// the report into the result register. A stalled report holds in the result
// register; the parser keeps taking bytes that do not close a frame, and stalls
// the rx channel only when a second end byte meets a full result register.
// Reset clears the configuration registers, the parse state and both valid
// flags.
module gamepad_report_deframer_core
  import gprd_pkg::*;
(
  input logic           clk,
  input logic           rst,
  gprd_byte_if.sink     rx,
  gprd_cfg_if.sink      cfg,
  gprd_report_if.source report
);

  cfg_regs_t  regs;
  frame_evt_t evt;
  logic       res_free;

  gprd_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  gprd_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx),
    .regs     (regs),
    .res_free (res_free),
    .evt      (evt)
  );

  gprd_result u_result (
    .clk      (clk),
    .rst      (rst),
    .evt      (evt),
    .regs     (regs),
    .res_free (res_free),
    .report   (report)
  );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the gamepad report deframer: byte frames in, decoded reports out.
module testbench;
  import gprd_pkg::*;

  localparam int HalfPeriod = 6;
  localparam int ResetCycles = 4;
  localparam int NumPhases = 6;
  localparam int PhaseBytes = 150;
  localparam int SettleCycles = 8;
  localparam int HoldOffCycles = 300;
  localparam int TimeoutCycles = 600000;

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [CfgIndexW-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CfgIndexW-1:0] REG_SPARE_B = 3'd7;

  typedef enum logic [1:0] {SEEK_START, READ_LENGTH, READ_PAYLOAD, READ_END} deframe_state_t;
  typedef enum logic [1:0] {FILL_ZEROS, FILL_ONES, FILL_RANDOM, FILL_MARKERS} fill_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  report_ident;
    logic [7:0]  timer_value;
    logic [7:0]  info_byte;
    logic [7:0]  buttons_low;
    logic [7:0]  buttons_mid;
    logic [7:0]  buttons_high;
    logic [12:0] left_x;
    logic [12:0] left_y;
    logic [12:0] right_x;
    logic [12:0] right_y;
  } report_t;

  // One byte to send; an end byte may carry a hand-written expected report.
  typedef struct packed {
    logic [7:0] data;
    logic       pinned;
    report_t    want;
  } rx_item_t;

  // One directed frame, preceded by a few bytes that the hunt must skip.
  typedef struct packed {
    logic [3:0] noise;
    logic [7:0] len;
    fill_t      fill;
    logic       end_ok;
    logic       pinned;
    report_t    want;
  } frame_row_t;

  localparam report_t RPT_NONE = '0;
  localparam report_t RPT_BAD_END = {STATUS_BAD_END, 100'b0};
  localparam report_t RPT_SHORT = {STATUS_SHORT, 100'b0};
  // All-ones payload: every stick sits at +2047 with zero offsets.
  localparam report_t RPT_ONES = {STATUS_GOOD, {6{8'hFF}}, {4{13'h07FF}}};
  // All-zeros payload: every stick sits at -2048 with zero offsets.
  localparam report_t RPT_ZEROS = {STATUS_GOOD, 48'h0, {4{13'h1800}}};

  // Directed frames, sent with the registers at their reset values.
  localparam int NumRows = 10;
  localparam frame_row_t DirectedFrames [NumRows] = '{
    {4'd2, 8'd12,  FILL_ONES,    1'b1, 1'b1, RPT_ONES},
    {4'd0, 8'd12,  FILL_ZEROS,   1'b1, 1'b1, RPT_ZEROS},
    {4'd1, 8'd12,  FILL_RANDOM,  1'b0, 1'b1, RPT_BAD_END},
    {4'd0, 8'd3,   FILL_RANDOM,  1'b0, 1'b1, RPT_BAD_END},
    {4'd0, 8'd11,  FILL_RANDOM,  1'b1, 1'b1, RPT_SHORT},
    {4'd0, 8'd0,   FILL_RANDOM,  1'b1, 1'b1, RPT_SHORT},
    {4'd0, 8'd0,   FILL_RANDOM,  1'b0, 1'b1, RPT_BAD_END},
    {4'd0, 8'd13,  FILL_RANDOM,  1'b1, 1'b0, RPT_NONE},
    {4'd3, 8'd12,  FILL_MARKERS, 1'b1, 1'b0, RPT_NONE},
    {4'd0, 8'd255, FILL_RANDOM,  1'b1, 1'b0, RPT_NONE}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  gprd_byte_if   rx_ch ();
  gprd_cfg_if    cfg_ch ();
  gprd_report_if rpt_ch ();

  gamepad_report_deframer_core dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .cfg    (cfg_ch),
    .report (rpt_ch)
  );

  always #HalfPeriod clk = ~clk;

  // Deframer model state and its copy of the registers.
  cfg_regs_t      regs_model;
  deframe_state_t rx_state;
  logic [7:0]     hdr_len;
  logic [7:0]     bytes_seen;
  logic [7:0]     capture [CaptureLen];

  rx_item_t rx_queue [$];
  rx_item_t rx_cur;
  bit       rx_busy;
  report_t  pending_reports [$];

  bit rx_gaps_on;
  bit rpt_stalls_on;
  bit hold_off_req;

  int mismatches;
  int bytes_taken;
  int rx_stall_cycles;
  int cycle_count;
  int n_good;
  int n_bad_end;
  int n_short;

  function automatic void reset_model();
    regs_model = '0;
    rx_state = SEEK_START;
    hdr_len = '0;
    bytes_seen = '0;
    foreach (capture[i]) capture[i] = '0;
  endfunction

  function automatic void load_register(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] val);
    case (idx)
      REG_START_MARKER: regs_model.start_marker = val[7:0];
      REG_END_MARKER:   regs_model.end_marker = val[7:0];
      REG_NEUTRAL_LX:   regs_model.neutral_left_x = val;
      REG_NEUTRAL_LY:   regs_model.neutral_left_y = val;
      REG_NEUTRAL_RX:   regs_model.neutral_right_x = val;
      REG_NEUTRAL_RY:   regs_model.neutral_right_y = val;
      default: ;
    endcase
  endfunction

  // Raw 12-bit stick minus the center minus the signed rest offset, kept to 13 bits.
  function automatic logic [12:0] center_stick(logic [11:0] raw, logic signed [11:0] neutral);
    int diff;
    diff = int'(raw) - int'(StickCentre) - int'(neutral);
    return diff[12:0];
  endfunction

  // Advances the deframer model by one byte; fired says a report is due.
  function automatic void deframe_byte(input logic [7:0] b, output bit fired,
                                       output report_t r);
    fired = 1'b0;
    r = '0;
    case (rx_state)
      SEEK_START: begin
        if (b == regs_model.start_marker) rx_state = READ_LENGTH;
      end
      READ_LENGTH: begin
        hdr_len = b;
        bytes_seen = '0;
        rx_state = (b == 8'd0) ? READ_END : READ_PAYLOAD;
      end
      READ_PAYLOAD: begin
        if (bytes_seen < CaptureLen) capture[bytes_seen] = b;
        bytes_seen = bytes_seen + 8'd1;
        if (bytes_seen == hdr_len) rx_state = READ_END;
      end
      default: begin
        rx_state = SEEK_START;
        fired = 1'b1;
        // A wrong end marker is reported ahead of a short length.
        if (b != regs_model.end_marker) begin
          r.status = STATUS_BAD_END;
        end else if (hdr_len < CaptureLen) begin
          r.status = STATUS_SHORT;
        end else begin
          r.status = STATUS_GOOD;
          r.report_ident = capture[0];
          r.timer_value = capture[1];
          r.info_byte = capture[2];
          r.buttons_low = capture[3];
          r.buttons_mid = capture[4];
          r.buttons_high = capture[5];
          r.left_x = center_stick({capture[7][3:0], capture[6]}, regs_model.neutral_left_x);
          r.left_y = center_stick({capture[8], capture[7][7:4]}, regs_model.neutral_left_y);
          r.right_x = center_stick({capture[10][3:0], capture[9]}, regs_model.neutral_right_x);
          r.right_y = center_stick({capture[11], capture[10][7:4]}, regs_model.neutral_right_y);
        end
      end
    endcase
  endfunction

  function automatic void cmp_field(string name, logic [12:0] want, logic [12:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void push_byte(logic [7:0] d);
    rx_queue.push_back({d, 1'b0, RPT_NONE});
  endfunction

  // A byte that differs from the start marker, so the hunt skips it.
  function automatic void push_noise();
    push_byte(regs_model.start_marker ^ 8'($urandom_range(1, 255)));
  endfunction

  // Queues start marker, length, payload and end byte of one frame.
  function automatic void push_frame(logic [7:0] len, fill_t fill, bit end_ok, bit pinned,
                                     report_t want);
    logic [7:0] b;
    rx_item_t   last;
    push_byte(regs_model.start_marker);
    push_byte(len);
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ZEROS:   b = 8'h00;
        FILL_ONES:    b = 8'hFF;
        FILL_MARKERS: b = ($urandom_range(0, 2) == 0) ? regs_model.start_marker : 8'($urandom);
        default:      b = 8'($urandom);
      endcase
      push_byte(b);
    end
    last.data = end_ok ? regs_model.end_marker
                       : regs_model.end_marker ^ 8'($urandom_range(1, 255));
    last.pinned = pinned;
    last.want = want;
    rx_queue.push_back(last);
  endfunction

  task automatic cfg_put(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic wait_rx_idle();
    while (rx_queue.size() != 0 || rx_busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Brings the parser back to the hunt and waits until every report is in.
  task automatic quiesce();
    wait_rx_idle();
    while (rx_state != SEEK_START) begin
      push_byte(rx_state == READ_LENGTH ? 8'd0 : 8'($urandom));
      wait_rx_idle();
    end
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Byte sender: one item per handshake, with random gaps between items while rx_gaps_on is set.
  initial begin : byte_source
    int idle;
    idle = 0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (idle > 0 || rx_queue.size() == 0) begin
        rx_ch.valid <= 1'b0;
        if (idle > 0) idle--;
      end else begin
        rx_cur = rx_queue.pop_front();
        rx_busy = 1'b1;
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= rx_cur.data;
        do @(posedge clk); while (!rx_ch.ready);
        rx_busy = 1'b0;
        if (rx_gaps_on) idle = idle_cycles();
      end
    end
  end

  // Report receiver: random stalls while rpt_stalls_on is set, plus one long hold-off on request.
  initial begin : report_sink
    int stall_left;
    stall_left = 0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = HoldOffCycles;
      end
      if (stall_left > 0) begin
        rpt_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rpt_ch.ready <= 1'b1;
        if (rpt_stalls_on) stall_left = idle_cycles();
      end
    end
  end

  // Predicts on every accepted byte and checks every accepted report in order.
  always @(posedge clk) begin : scoreboard
    bit      fired;
    report_t predicted;
    report_t seen;
    report_t want;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) load_register(cfg_ch.index, cfg_ch.data);
      if (rx_ch.valid && !rx_ch.ready) rx_stall_cycles++;
      if (rx_ch.valid && rx_ch.ready) begin
        bytes_taken++;
        deframe_byte(rx_ch.rx_byte, fired, predicted);
        if (fired) pending_reports.push_back(rx_cur.pinned ? rx_cur.want : predicted);
      end
      if (rpt_ch.valid && rpt_ch.ready) begin
        seen = {rpt_ch.status, rpt_ch.report_ident, rpt_ch.timer_value, rpt_ch.info_byte,
                rpt_ch.buttons_low, rpt_ch.buttons_mid, rpt_ch.buttons_high,
                rpt_ch.left_x, rpt_ch.left_y, rpt_ch.right_x, rpt_ch.right_y};
        if (seen.status == STATUS_GOOD) n_good++;
        else if (seen.status == STATUS_BAD_END) n_bad_end++;
        else n_short++;
        if (pending_reports.size() == 0) begin
          $display("%0t: report with nothing expected, actual status %0h", $time, seen.status);
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          cmp_field("status", want.status, seen.status);
          cmp_field("report_ident", want.report_ident, seen.report_ident);
          cmp_field("timer_value", want.timer_value, seen.timer_value);
          cmp_field("info_byte", want.info_byte, seen.info_byte);
          cmp_field("buttons_low", want.buttons_low, seen.buttons_low);
          cmp_field("buttons_mid", want.buttons_mid, seen.buttons_mid);
          cmp_field("buttons_high", want.buttons_high, seen.buttons_high);
          cmp_field("left_x", want.left_x, seen.left_x);
          cmp_field("left_y", want.left_y, seen.left_y);
          cmp_field("right_x", want.right_x, seen.right_x);
          cmp_field("right_y", want.right_y, seen.right_y);
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > TimeoutCycles) begin
      $display("%0t: timeout, %0d reports outstanding", $time, pending_reports.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Reset, directed frames, then random phases under changing register settings.
  initial begin : stimulus
    cfg_regs_t  next_cfg;
    int         phase_items;
    int         pick;
    int         cut;
    logic [7:0] len;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    rpt_ch.ready = 1'b0;
    reset_model();
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed frames with reset register values: both markers and all offsets zero.
    rx_gaps_on = 1'b1;
    rpt_stalls_on = 1'b1;
    foreach (DirectedFrames[r]) begin
      repeat (DirectedFrames[r].noise) push_noise();
      push_frame(DirectedFrames[r].len, DirectedFrames[r].fill, DirectedFrames[r].end_ok,
                 DirectedFrames[r].pinned, DirectedFrames[r].want);
    end
    quiesce();

    for (int p = 0; p < NumPhases; p++) begin
      // The first two settings take the markers and offsets to their extremes.
      case (p)
        0:       next_cfg = {8'hFF, 8'h00, {4{12'h800}}};
        1:       next_cfg = {8'h00, 8'hFF, {4{12'h7FF}}};
        default: next_cfg = {$urandom, $urandom};
      endcase
      cfg_put(REG_START_MARKER, {4'($urandom), next_cfg.start_marker});
      cfg_put(REG_END_MARKER, {4'($urandom), next_cfg.end_marker});
      cfg_put(REG_NEUTRAL_LX, next_cfg.neutral_left_x);
      cfg_put(REG_NEUTRAL_LY, next_cfg.neutral_left_y);
      cfg_put(REG_NEUTRAL_RX, next_cfg.neutral_right_x);
      cfg_put(REG_NEUTRAL_RY, next_cfg.neutral_right_y);
      cfg_put(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B, 12'($urandom));
      @(negedge clk);
      cfg_ch.valid <= 1'b0;

      // The first phase runs at full rate on both sides; one later phase holds reports off.
      rx_gaps_on = (p != 0) && ($urandom_range(0, 3) != 0);
      rpt_stalls_on = (p != 0) && ($urandom_range(0, 3) != 0);
      if (p == 2) hold_off_req = 1'b1;

      phase_items = 0;
      while (phase_items < PhaseBytes) begin
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
          // Good frame, mostly the minimum length, now and then the longest.
          if ($urandom_range(0, 199) == 0) len = 8'd255;
          else if ($urandom_range(0, 4) != 0) len = 8'd12;
          else len = 8'($urandom_range(13, 40));
          push_frame(len, ($urandom_range(0, 4) == 0) ? FILL_MARKERS : FILL_RANDOM,
                     1'b1, 1'b0, RPT_NONE);
          phase_items += len + 3;
        end else if (pick < 74) begin
          len = 8'($urandom_range(0, 20));
          push_frame(len, FILL_RANDOM, 1'b0, 1'b0, RPT_NONE);
          phase_items += len + 3;
        end else if (pick < 84) begin
          len = 8'($urandom_range(0, 11));
          push_frame(len, FILL_RANDOM, 1'b1, 1'b0, RPT_NONE);
          phase_items += len + 3;
        end else if (pick < 92) begin
          repeat ($urandom_range(1, 6)) push_noise();
        end else begin
          // Truncated frame: the parser swallows the bytes that follow.
          len = 8'($urandom_range(12, 20));
          cut = $urandom_range(1, len - 1);
          push_byte(regs_model.start_marker);
          push_byte(len);
          repeat (cut) push_byte(8'($urandom));
          phase_items += cut + 2;
        end
      end
      quiesce();
    end

    $display("Sent %0d bytes under %0d register settings; byte input stalled for %0d cycles.",
             bytes_taken, NumPhases + 1, rx_stall_cycles);
    $display("Checked %0d reports: %0d good, %0d wrong end marker, %0d short length.",
             n_good + n_bad_end + n_short, n_good, n_bad_end, n_short);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/gprd_pkg.sv
src/gprd_byte_if.sv
src/gprd_report_if.sv
src/gprd_cfg_if.sv
src/gprd_cfg.sv
src/gprd_parser.sv
src/gprd_result.sv
src/gamepad_report_deframer_core.sv
tb/testbench.sv
